### rtl/icon_palette_quantizer_macros.svh
// assertion macros shared by the icon palette quantizer modules
`ifndef ICON_PALETTE_QUANTIZER_MACROS_SVH
`define ICON_PALETTE_QUANTIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define IPQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IPQ_ASSERT_ALWAYS(label, cond, msg)
`define IPQ_ASSERT_IMPLY(label, ante, cons, msg)
`define IPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/ipq_pkg.sv
// shared types and constants of the icon palette quantizer
package ipq_pkg;

    localparam int ICON_SIZE     = 32;
    localparam int PALETTE_SIZE  = 16;
    localparam int SIZE_W        = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int ADDR_W        = 9;
    localparam int IDX_W         = 4;
    localparam int COLOR_W       = 16;
    localparam int COORD_W       = $clog2(ICON_SIZE);
    localparam int SPAN_W        = COORD_W + 1;
    localparam int STORE_BYTES   = (ICON_SIZE * ICON_SIZE) / 2;
    localparam int POS_W         = $clog2(STORE_BYTES);
    localparam int TILE_W        = POS_W - 5;
    localparam int TILES_PER_ROW = ICON_SIZE / 8;
    localparam int ROW_BYTES     = 8;
    localparam int ROW_COUNT     = STORE_BYTES / ROW_BYTES;
    localparam int ROW_AW        = POS_W - 3;
    localparam int LANE_W        = 3;
    localparam int USED_W        = $clog2(PALETTE_SIZE + 1);
    localparam int PAL_AW        = $clog2(PALETTE_SIZE);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       first_pixel;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  byte_address;
        logic [7:0]         byte_value;
        logic [IDX_W-1:0]   palette_index;
        logic [COLOR_W-1:0] color_word;
        logic               color_added;
        logic               color_dropped;
        logic               last_pixel;
    } result_t;

    typedef struct packed {
        logic load;
        logic look;
        logic write;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

endpackage

### rtl/ipq_ctrl.sv
// request sequencing for the icon palette quantizer
`include "icon_palette_quantizer_macros.svh"
module ipq_ctrl
    import ipq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_stall,
    output logic result_valid,
    input  logic result_stall,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    // output register is empty or being drained this cycle
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next  = state_reg;
        pixel_stall = 1'b1;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                pixel_stall = 1'b0;
                if (pixel_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.write   = 1'b1;
                    pixel_stall = 1'b0;
                    state_next  = pixel_valid ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.load = pixel_valid && !pixel_stall;
    end

    always_comb
    begin
        if (cmd.write)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    `IPQ_ASSERT_NEXT(a_accept_to_look, pixel_valid && !pixel_stall, state_reg == S_LOOK, "accepted request did not start lookup")
    `IPQ_ASSERT_IMPLY(a_write_needs_slot, cmd.write, !(result_valid_reg && result_stall), "write into occupied output register")
    `IPQ_ASSERT_NEXT(a_write_shows_result, cmd.write, result_valid_reg, "write did not present a result")

endmodule

### rtl/ipq_dp.sv
// palette lookup, tile addressing and icon row memory of the quantizer
`include "icon_palette_quantizer_macros.svh"
module ipq_dp
    import ipq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  pixel_t               pixel,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output result_t              result
);

    localparam int CMP_W = (SIZE_W > SPAN_W) ? SIZE_W : SPAN_W;
    localparam int ROW_W = ROW_BYTES * 8;

    function automatic logic [SPAN_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve == '0)
        begin
            return SPAN_W'(1);
        end
        if (ve > CMP_W'(ICON_SIZE))
        begin
            return SPAN_W'(ICON_SIZE);
        end
        return SPAN_W'(ve);
    endfunction

    function automatic logic pixel_green_bit2(input pixel_t p);
        return p.green[2];
    endfunction

    logic [SIZE_W-1:0]  width_reg, height_reg;
    pixel_t             pix_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [USED_W-1:0]  used_reg;
    logic [COLOR_W-1:0] pal_reg [1:PALETTE_SIZE-1];
    logic [ROW_COUNT-1:0] row_valid_reg;
    logic [ROW_W-1:0]   mem [ROW_COUNT];

    logic [ROW_AW-1:0]  row_s_reg;
    logic [LANE_W-1:0]  lane_s_reg;
    logic               high_s_reg;
    logic [IDX_W-1:0]   idx_s_reg;
    logic [COLOR_W-1:0] color_s_reg;
    logic               added_s_reg, dropped_s_reg, last_s_reg;
    logic [ROW_W-1:0]   rd_row_reg;
    logic               rd_ok_reg;
    result_t            result_reg;

    logic [SPAN_W-1:0]  w, h;
    logic [SPAN_W-1:0]  col_base, row_base;
    logic [COORD_W-1:0] col_eff, row_eff, x, y;
    logic [TILE_W-1:0]  tile;
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
    logic [USED_W-1:0]  used_eff;
    logic [PALETTE_SIZE-1:1] hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               opaque, found, add, drop;
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic [SPAN_W-1:0]  col_inc, row_inc;
    logic [COORD_W-1:0] col_next, row_next;

    logic [ROW_W-1:0]   base_row, new_row;
    logic [7:0]         old_byte, new_byte;

    assign w = clamp_size(width_reg);
    assign h = clamp_size(height_reg);

    // a new image restarts at the top left corner
    assign col_base = pix_reg.first_pixel ? '0 : SPAN_W'(col_reg);
    assign row_base = pix_reg.first_pixel ? '0 : SPAN_W'(row_reg);
    assign col_eff  = (col_base >= w) ? '0 : COORD_W'(col_base);
    assign row_eff  = (row_base >= h) ? '0 : COORD_W'(row_base);

    assign x = COORD_W'(((SPAN_W'(ICON_SIZE) - w) >> 1) + SPAN_W'(col_eff));
    assign y = COORD_W'(((SPAN_W'(ICON_SIZE) - h) >> 1) + SPAN_W'(row_eff));

    // 8x8 tiles of 32 bytes, four bytes per tile line
    assign tile = TILE_W'(TILE_W'(y >> 3) * TILE_W'(TILES_PER_ROW)) + TILE_W'(x >> 3);
    assign pos  = {tile, y[2:0], x[2:1]};

    assign color = {pixel_green_bit2(pix_reg), pix_reg.blue[7:3], pix_reg.green[7:3],
                    pix_reg.red[7:3]};

    assign used_eff = pix_reg.first_pixel ? USED_W'(1) : used_reg;
    assign opaque   = (pix_reg.alpha == 8'hFF);

    always_comb
    begin
        hit     = '0;
        hit_idx = '0;
        for (int k = PALETTE_SIZE - 1; k >= 1; k--)
        begin
            hit[k] = (USED_W'(k) < used_eff) && (pal_reg[k] == color);
            if (hit[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign found = |hit;
    assign add   = opaque && !found && (used_eff < USED_W'(PALETTE_SIZE));
    assign drop  = opaque && !found && !add;

    always_comb
    begin
        if (opaque && found)
        begin
            idx = hit_idx;
        end
        else if (add)
        begin
            idx = IDX_W'(used_eff);
        end
        else
        begin
            idx = '0;
        end
    end

    assign last    = (SPAN_W'(col_eff) + SPAN_W'(1) == w) && (SPAN_W'(row_eff) + SPAN_W'(1) == h);
    assign col_inc = SPAN_W'(col_eff) + SPAN_W'(1);
    assign row_inc = SPAN_W'(row_eff) + SPAN_W'(1);

    always_comb
    begin
        if (col_inc >= w)
        begin
            col_next = '0;
            row_next = (row_inc >= h) ? '0 : COORD_W'(row_inc);
        end
        else
        begin
            col_next = COORD_W'(col_inc);
            row_next = row_eff;
        end
    end

    // rows never written since the image started read as zero
    assign base_row = rd_ok_reg ? rd_row_reg : '0;
    assign old_byte = base_row[lane_s_reg*8 +: 8];
    assign new_byte = high_s_reg ? {idx_s_reg, old_byte[3:0]} : {old_byte[7:4], idx_s_reg};

    always_comb
    begin
        for (int j = 0; j < ROW_BYTES; j++)
        begin
            new_row[j*8 +: 8] = (LANE_W'(j) == lane_s_reg) ? new_byte : base_row[j*8 +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_W'(ICON_SIZE);
            height_reg    <= SIZE_W'(ICON_SIZE);
            col_reg       <= '0;
            row_reg       <= '0;
            used_reg      <= USED_W'(1);
            row_valid_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.look)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                used_reg <= used_eff + USED_W'(add);
                if (pix_reg.first_pixel)
                begin
                    row_valid_reg <= '0;
                end
            end
            if (cmd.write)
            begin
                row_valid_reg[row_s_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg <= pixel;
        end
        if (cmd.look)
        begin
            if (add)
            begin
                pal_reg[used_eff[PAL_AW-1:0]] <= color;
            end
            row_s_reg     <= pos[POS_W-1:LANE_W];
            lane_s_reg    <= pos[LANE_W-1:0];
            high_s_reg    <= x[0];
            idx_s_reg     <= idx;
            color_s_reg   <= color;
            added_s_reg   <= add;
            dropped_s_reg <= drop;
            last_s_reg    <= last;
            rd_row_reg    <= mem[pos[POS_W-1:LANE_W]];
            rd_ok_reg     <= row_valid_reg[pos[POS_W-1:LANE_W]] && !pix_reg.first_pixel;
        end
        if (cmd.write)
        begin
            mem[row_s_reg]            <= new_row;
            result_reg.byte_address   <= ADDR_W'({row_s_reg, lane_s_reg});
            result_reg.byte_value     <= new_byte;
            result_reg.palette_index  <= idx_s_reg;
            result_reg.color_word     <= color_s_reg;
            result_reg.color_added    <= added_s_reg;
            result_reg.color_dropped  <= dropped_s_reg;
            result_reg.last_pixel     <= last_s_reg;
        end
    end

    assign result = result_reg;

    `IPQ_ASSERT_ALWAYS(a_used_range,
        (used_reg >= USED_W'(1)) && (used_reg <= USED_W'(PALETTE_SIZE)),
        "palette fill out of range")
    `IPQ_ASSERT_NEXT(a_first_restarts, cmd.look && pix_reg.first_pixel,
        used_reg <= USED_W'(2), "new image kept old palette")
    `IPQ_ASSERT_NEXT(a_write_marks_row, cmd.write, row_valid_reg[row_s_reg],
        "written row not marked valid")

endmodule

### rtl/icon_palette_quantizer.sv
// top level of the icon palette quantizer: pixels in, icon byte updates out
//
//   channel   handshake                  payload
//   pixel     pixel_valid / pixel_stall  pixel (pixel_t)
//   result    result_valid / result_stall result (result_t)
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// a pixel is accepted, then compared against the palette while its icon row is read, then
// nibble merged into the row as it is written; the next pixel is accepted in the write cycle,
// not before, as the single-port icon row memory takes a read-merge-write of one row per pixel
// reset clears position counters, palette fill and the row valid bits at once; no clearing pass
// a result waits in the output register; a stalled result holds back only the write cycle
module icon_palette_quantizer
    import ipq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  pixel_t               pixel,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    ipq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    ipq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pixel     (pixel),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
